### rtl/trsd_pkg.sv
// Shared types and constants for the TGA run-length span decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package trsd_pkg;

  // Configuration register indexes
  localparam logic [0:0] CFG_BPP   = 1'b0;
  localparam logic [0:0] CFG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_EARLY_END = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  // Packet header split point and run length bias
  localparam logic [7:0] RUN_FLAG = 8'd128;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  span_length;
    logic [23:0] start_index;
    logic        image_done;
    err_e        error_code;
  } span_t;

endpackage

`default_nettype wire

### rtl/tga_rle_span_decoder.sv
// Top level of the TGA run-length span decoder: input register, decoder, result register.
// Depends on trsd_pkg, trsd_cfg and trsd_decode.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one byte of the run-length
//   pixel stream per request, or a stream_end_i flag when the source runs dry.
//   The output channel (out_valid_o / out_stall_i) carries one span per finished
//   pixel: its value, length, start position, an image-done flag and an error code.
//   Header bytes and partial pixel bytes give no span.
//   An accepted byte enters the input register, and its span is loaded into the result
//   register when the decode step runs, which waits while a held result is stalled.
//   Throughput is one byte per cycle unless the receiver stalls, set by the single decode
//   step between the two registers; the packet state is updated in that same cycle.
//   When the receiver stalls, the result register holds; one more byte may sit in
//   the input register, after which in_stall_o is raised until the result is taken.
//   Reset clears the packet state and loads bytes_per_pixel = 3, pixel_count = 1.
//   After a finished image or an error the decoder clears itself for the next image.
//   Configuration writes (cfg_we_i) take effect at once and belong in idle time.
`default_nettype none

module tga_rle_span_decoder #(
  parameter int COUNT_BITS = 25
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [0:0]            cfg_idx_i,
  input  wire  [COUNT_BITS-1:0] cfg_wdata_i,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [7:0]            data_byte_i,
  input  wire                   stream_end_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [31:0]           pixel_value_o,
  output logic [7:0]            span_length_o,
  output logic [23:0]           start_index_o,
  output logic                  image_done_o,
  output logic [1:0]            error_code_o
);
  import trsd_pkg::*;

  logic                  s1_valid_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_end_q;
  logic                  out_valid_q;
  span_t                 out_q;
  logic                  s2_free;
  logic                  step;
  logic [2:0]            bpp;
  logic [COUNT_BITS-1:0] count;
  logic                  res_valid;
  span_t                 res;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;

  trsd_cfg #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bpp_o       (bpp),
    .count_o     (count)
  );

  trsd_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .data_byte_i  (s1_byte_q),
    .stream_end_i (s1_end_q),
    .bpp_i        (bpp),
    .count_i      (count),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Input register: refill whenever the held request moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_byte_q <= data_byte_i;
      s1_end_q  <= stream_end_i;
    end
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = out_q.pixel_value;
  assign span_length_o = out_q.span_length;
  assign start_index_o = out_q.start_index;
  assign image_done_o  = out_q.image_done;
  assign error_code_o  = out_q.error_code;

  // Input side stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled with result register free");

  // A stream end always yields a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_end_q |=> out_valid_q && out_q.error_code == ERR_EARLY_END)
    else $error("stream end gave no error result");

  // Early end carries no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error_code == ERR_EARLY_END
    |-> out_q.span_length == 8'd0 && out_q.pixel_value == 32'd0 && !out_q.image_done)
    else $error("early end result carries a pixel");

  // Completion and error are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.image_done |-> out_q.error_code == ERR_NONE)
    else $error("image done flagged on an error result");

endmodule

`default_nettype wire

### rtl/trsd_cfg.sv
// Configuration registers of the span decoder and their effective values.
// Depends on trsd_pkg for the register indexes.
`default_nettype none

module trsd_cfg #(
  parameter int COUNT_BITS = 25
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire  [0:0]            cfg_idx_i,
  input  wire  [COUNT_BITS-1:0] cfg_wdata_i,
  output logic [2:0]            bpp_o,
  output logic [COUNT_BITS-1:0] count_o
);
  import trsd_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountLim = COUNT_BITS'(1) << (COUNT_BITS - 1);

  logic [2:0]            bpp_q;
  logic [COUNT_BITS-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= 3'd3;
      count_q <= COUNT_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BPP:   bpp_q   <= cfg_wdata_i[2:0];
        CFG_COUNT: count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Fold out-of-range widths onto the nearest legal one
  always_comb begin
    case (bpp_q)
      3'd0:    bpp_o = 3'd1;
      3'd1:    bpp_o = 3'd1;
      3'd2:    bpp_o = 3'd2;
      3'd3:    bpp_o = 3'd3;
      default: bpp_o = 3'd4;
    endcase
  end

  // Saturate the image size at half the counter range
  assign count_o = (count_q > CountLim) ? CountLim : count_q;

endmodule

`default_nettype wire

### rtl/trsd_decode.sv
// Packet decoder of the span decoder: packet state, pixel gathering and span results.
// Depends on trsd_pkg for the result type, error codes and header constants.
`default_nettype none

module trsd_decode #(
  parameter int COUNT_BITS = 25
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  wire  [7:0]            data_byte_i,
  input  wire                   stream_end_i,
  input  wire  [2:0]            bpp_i,
  input  wire  [COUNT_BITS-1:0] count_i,
  output logic                  res_valid_o,
  output trsd_pkg::span_t       res_o
);
  import trsd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RAW    = 2'd1,
    PH_RUN    = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [7:0]            raw_left_q, raw_left_d;
  logic [1:0]            byte_pos_q, byte_pos_d;
  logic [31:0]           acc_q, acc_d;
  logic [7:0]            run_len_q, run_len_d;
  logic [COUNT_BITS-1:0] done_q, done_d;

  logic [2:0]            bp_next;
  logic [31:0]           acc_new;
  logic [7:0]            len;
  logic [COUNT_BITS-1:0] len_ext;
  logic [COUNT_BITS-1:0] remaining;
  logic [COUNT_BITS-1:0] done_sum;
  logic [7:0]            raw_dec;
  logic                  pkt_end;

  always_comb begin
    bp_next   = {1'b0, byte_pos_q} + 3'd1;
    acc_new   = acc_q | (32'(data_byte_i) << {byte_pos_q, 3'b000});
    len       = (phase_q == PH_RAW) ? 8'd1 : run_len_q;
    len_ext   = COUNT_BITS'(len);
    remaining = (done_q < count_i) ? (count_i - done_q) : '0;
    done_sum  = done_q + len_ext;
    raw_dec   = raw_left_q - 8'd1;
    pkt_end   = (phase_q == PH_RUN) || (raw_dec == 8'd0);
  end

  always_comb begin
    phase_d     = phase_q;
    raw_left_d  = raw_left_q;
    byte_pos_d  = byte_pos_q;
    acc_d       = acc_q;
    run_len_d   = run_len_q;
    done_d      = done_q;
    res_valid_o = 1'b0;
    res_o       = '{pixel_value: 32'd0, span_length: 8'd0,
                    start_index: 24'(done_q), image_done: 1'b0,
                    error_code: ERR_NONE};

    if (stream_end_i) begin
      res_valid_o      = 1'b1;
      res_o.error_code = ERR_EARLY_END;
      phase_d          = PH_HEADER;
      raw_left_d       = '0;
      byte_pos_d       = '0;
      acc_d            = '0;
      run_len_d        = '0;
      done_d           = '0;
    end else begin
      case (phase_q)
        PH_RAW, PH_RUN: begin
          if (bp_next < bpp_i) begin
            byte_pos_d = bp_next[1:0];
            acc_d      = acc_new;
          end else begin
            res_valid_o       = 1'b1;
            res_o.pixel_value = acc_new;
            byte_pos_d        = '0;
            acc_d             = '0;
            if (len_ext > remaining) begin
              // Clip the span to what is left and drop the image
              res_o.span_length = remaining[7:0];
              res_o.error_code  = ERR_OVERFLOW;
              phase_d           = PH_HEADER;
              raw_left_d        = '0;
              run_len_d         = '0;
              done_d            = '0;
            end else begin
              res_o.span_length = len;
              if (phase_q == PH_RAW) begin
                raw_left_d = raw_dec;
              end
              if (pkt_end) begin
                phase_d = PH_HEADER;
              end
              done_d = done_sum;
              if (pkt_end && (done_sum == count_i)) begin
                res_o.image_done = 1'b1;
                raw_left_d       = '0;
                run_len_d        = '0;
                done_d           = '0;
              end
            end
          end
        end
        default: begin
          if (data_byte_i < RUN_FLAG) begin
            phase_d    = PH_RAW;
            raw_left_d = data_byte_i + 8'd1;
          end else begin
            phase_d   = PH_RUN;
            run_len_d = data_byte_i - RUN_BIAS;
          end
          byte_pos_d = '0;
          acc_d      = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      raw_left_q <= '0;
      byte_pos_q <= '0;
      acc_q      <= '0;
      run_len_q  <= '0;
      done_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      raw_left_q <= raw_left_d;
      byte_pos_q <= byte_pos_d;
      acc_q      <= acc_d;
      run_len_q  <= run_len_d;
      done_q     <= done_d;
    end
  end

  // A raw packet in progress always has pixels left to take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RAW |-> raw_left_q != 8'd0)
    else $error("raw packet open with no pixels left");

  // A span without error always covers at least one pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && res_o.error_code == ERR_NONE |-> res_o.span_length != 8'd0)
    else $error("empty span without error");

  // A finished image or an error restarts from pixel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && (res_o.image_done || res_o.error_code != ERR_NONE)
    |=> done_q == '0 && phase_q == PH_HEADER)
    else $error("decoder not cleared after image end");

endmodule

`default_nettype wire
